// ----- rtl/ldrs_pkg.sv -----
// Shared types and codes for the LOOK disk request scheduler.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package ldrs_pkg;

   localparam int SECTOR_BITS  = 48;
   localparam int TAG_BITS     = 8;
   localparam int PENDING_BITS = 6;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_DISPATCH = 2'd1;
   localparam logic [1:0] OP_REMOVE   = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]             op;
      logic [SECTOR_BITS-1:0] sector;
      logic [TAG_BITS-1:0]    tag;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [TAG_BITS-1:0]     out_tag;
      logic [SECTOR_BITS-1:0]  out_sector;
      logic                    going_up;
      logic [PENDING_BITS-1:0] pending;
   } rsp_type;

   typedef struct packed {
      logic                   valid;
      logic [SECTOR_BITS-1:0] sector;
      logic [TAG_BITS-1:0]    tag;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD
   } cell_cmd_type;

   typedef struct packed {
      logic                   bnd_found;
      logic [SECTOR_BITS-1:0] bnd_sector;
      logic [TAG_BITS-1:0]    bnd_tag;
      logic                   fb_found;
      logic [SECTOR_BITS-1:0] fb_sector;
      logic [TAG_BITS-1:0]    fb_tag;
      logic                   match_found;
   } pick_type;

endpackage

// ----- rtl/ldrs_cell.sv -----
// One queue cell: holds a single pending request and can take its neighbor's.
// Depends on ldrs_pkg for the entry and command types.
module ldrs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ldrs_pkg::cell_cmd_type cmd,
   input  ldrs_pkg::entry_type   nbr_entry,
   input  ldrs_pkg::entry_type   new_entry,
   output ldrs_pkg::entry_type   entry
);

   ldrs_pkg::entry_type entry_ff;
   ldrs_pkg::entry_type entry_in;

   always_comb begin
      unique case (cmd)
         ldrs_pkg::CELL_HOLD:  entry_in = entry_ff;
         ldrs_pkg::CELL_SHIFT: entry_in = nbr_entry;
         ldrs_pkg::CELL_LOAD:  entry_in = new_entry;
         default:              entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.sector <= entry_in.sector;
      entry_ff.tag    <= entry_in.tag;
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/ldrs_picker.sv -----
// Selection unit that watches the head cell while the queue rotates past it.
// Depends on ldrs_pkg; keeps the LOOK candidates and the first tag match.
module ldrs_picker #(
   parameter int IDX_W = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clear,
   input  logic                                 enable,
   input  ldrs_pkg::entry_type                  entry,
   input  logic [IDX_W-1:0]                     idx,
   input  logic [ldrs_pkg::SECTOR_BITS-1:0]     head,
   input  logic                                 up,
   input  logic [ldrs_pkg::TAG_BITS-1:0]        tag,
   output ldrs_pkg::pick_type                   pick,
   output logic [IDX_W-1:0]                     bnd_idx,
   output logic [IDX_W-1:0]                     fb_idx,
   output logic [IDX_W-1:0]                     match_idx
);

   ldrs_pkg::pick_type pick_ff;
   ldrs_pkg::pick_type pick_in;
   logic [IDX_W-1:0]   bnd_idx_ff, bnd_idx_in;
   logic [IDX_W-1:0]   fb_idx_ff, fb_idx_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic               in_bnd, bnd_better, fb_better;

   always_comb begin
      pick_in      = pick_ff;
      bnd_idx_in   = bnd_idx_ff;
      fb_idx_in    = fb_idx_ff;
      match_idx_in = match_idx_ff;
      in_bnd     = up ? (entry.sector >= head) : (entry.sector <= head);
      bnd_better = !pick_ff.bnd_found ||
                   (up ? (entry.sector < pick_ff.bnd_sector)
                       : (entry.sector > pick_ff.bnd_sector));
      fb_better  = !pick_ff.fb_found ||
                   (up ? (entry.sector > pick_ff.fb_sector)
                       : (entry.sector < pick_ff.fb_sector));
      if (clear) begin
         pick_in.bnd_found   = 1'b0;
         pick_in.fb_found    = 1'b0;
         pick_in.match_found = 1'b0;
      end else if (enable && entry.valid) begin
         if (in_bnd && bnd_better) begin
            pick_in.bnd_found  = 1'b1;
            pick_in.bnd_sector = entry.sector;
            pick_in.bnd_tag    = entry.tag;
            bnd_idx_in         = idx;
         end
         if (fb_better) begin
            pick_in.fb_found  = 1'b1;
            pick_in.fb_sector = entry.sector;
            pick_in.fb_tag    = entry.tag;
            fb_idx_in         = idx;
         end
         if (!pick_ff.match_found && entry.tag == tag) begin
            pick_in.match_found = 1'b1;
            match_idx_in        = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_ff.bnd_found   <= 1'b0;
         pick_ff.fb_found    <= 1'b0;
         pick_ff.match_found <= 1'b0;
      end else begin
         pick_ff.bnd_found   <= pick_in.bnd_found;
         pick_ff.fb_found    <= pick_in.fb_found;
         pick_ff.match_found <= pick_in.match_found;
      end
      pick_ff.bnd_sector <= pick_in.bnd_sector;
      pick_ff.bnd_tag    <= pick_in.bnd_tag;
      pick_ff.fb_sector  <= pick_in.fb_sector;
      pick_ff.fb_tag     <= pick_in.fb_tag;
      bnd_idx_ff         <= bnd_idx_in;
      fb_idx_ff          <= fb_idx_in;
      match_idx_ff       <= match_idx_in;
   end

   assign pick      = pick_ff;
   assign bnd_idx   = bnd_idx_ff;
   assign fb_idx    = fb_idx_ff;
   assign match_idx = match_idx_ff;

endmodule

// ----- rtl/look_disk_request_scheduler.sv -----
// LOOK disk request scheduler top level: a row of request cells in arrival order.
// Add, op 3 and a dispatch on an empty queue go from the idle step straight to the finish step.
// Dispatch and remove rotate the queue once past the selection unit, one cell a cycle,
// then the chosen cell, if there is one, is closed up by one shift.
// One item is worked on at a time, so the next item is taken only once the last has left
// the finish step; a finished result waits in an output register.
// Reset empties the queue, sets the head position to zero and the sweep to up.
module look_disk_request_scheduler #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ldrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ldrs_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DELETE,
      S_FINISH
   } state_type;

   state_type                           state_ff, state_in;
   ldrs_pkg::req_type                   req_ff, req_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [IDX_W-1:0]                    scan_ff, scan_in;
   logic [ldrs_pkg::SECTOR_BITS-1:0]    head_ff, head_in;
   logic                                sweep_ff, sweep_in;
   logic [1:0]                          status_ff, status_in;
   logic [ldrs_pkg::TAG_BITS-1:0]       res_tag_ff, res_tag_in;
   logic [ldrs_pkg::SECTOR_BITS-1:0]    res_sector_ff, res_sector_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ldrs_pkg::rsp_type                   rsp_ff, rsp_in;

   ldrs_pkg::entry_type                 cells [QUEUE_DEPTH];
   ldrs_pkg::entry_type                 new_entry;
   logic [QUEUE_DEPTH-1:0]              valid_vec;
   logic                                accept, pick_clear, pick_enable, do_delete;
   logic [IDX_W-1:0]                    del_idx;
   ldrs_pkg::pick_type                  pick;
   logic [IDX_W-1:0]                    bnd_idx, fb_idx, match_idx;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign new_entry = '{valid: 1'b1, sector: req_data.sector, tag: req_data.tag};
   assign del_idx   = (req_ff.op == ldrs_pkg::OP_REMOVE) ? match_idx :
                      (pick.bnd_found ? bnd_idx : fb_idx);
   assign do_delete = (state_ff == S_DELETE) &&
                      !(req_ff.op == ldrs_pkg::OP_REMOVE && !pick.match_found);

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      ldrs_pkg::cell_cmd_type cmd;
      ldrs_pkg::entry_type    nbr;

      if (i < QUEUE_DEPTH - 1) begin : g_inner
         assign nbr = cells[i+1];
      end else begin : g_last
         assign nbr = (state_ff == S_SCAN) ? cells[0] : '0;
      end

      always_comb begin
         if (accept && req_data.op == ldrs_pkg::OP_ADD && count_ff == CNT_W'(i)) begin
            cmd = ldrs_pkg::CELL_LOAD;
         end else if (state_ff == S_SCAN ||
                      (do_delete && IDX_W'(i) >= del_idx)) begin
            cmd = ldrs_pkg::CELL_SHIFT;
         end else begin
            cmd = ldrs_pkg::CELL_HOLD;
         end
      end

      ldrs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .nbr_entry (nbr),
         .new_entry (new_entry),
         .entry     (cells[i])
      );

      assign valid_vec[i] = cells[i].valid;
   end

   ldrs_picker #(
      .IDX_W (IDX_W)
   ) u_picker (
      .clock     (clock),
      .reset     (reset),
      .clear     (pick_clear),
      .enable    (pick_enable),
      .entry     (cells[0]),
      .idx       (scan_ff),
      .head      (head_ff),
      .up        (sweep_ff),
      .tag       (req_ff.tag),
      .pick      (pick),
      .bnd_idx   (bnd_idx),
      .fb_idx    (fb_idx),
      .match_idx (match_idx)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      head_in       = head_ff;
      sweep_in      = sweep_ff;
      status_in     = status_ff;
      res_tag_in    = res_tag_ff;
      res_sector_in = res_sector_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pick_clear    = 1'b0;
      pick_enable   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               status_in     = ldrs_pkg::ST_DONE;
               res_tag_in    = '0;
               res_sector_in = '0;
               scan_in       = '0;
               state_in      = S_FINISH;
               case (req_data.op)
                  ldrs_pkg::OP_ADD: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        status_in = ldrs_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ldrs_pkg::OP_DISPATCH: begin
                     if (count_ff == '0) begin
                        status_in = ldrs_pkg::ST_EMPTY;
                     end else begin
                        pick_clear = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
                  ldrs_pkg::OP_REMOVE: begin
                     pick_clear = 1'b1;
                     state_in   = S_SCAN;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            pick_enable = 1'b1;
            scan_in     = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
               state_in = S_DELETE;
            end
         end
         S_DELETE: begin
            if (!do_delete) begin
               status_in = ldrs_pkg::ST_NOT_FOUND;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (req_ff.op == ldrs_pkg::OP_DISPATCH) begin
                  res_tag_in    = pick.bnd_found ? pick.bnd_tag : pick.fb_tag;
                  res_sector_in = pick.bnd_found ? pick.bnd_sector : pick.fb_sector;
                  head_in       = res_sector_in;
                  sweep_in      = pick.bnd_found ? sweep_ff : !sweep_ff;
               end
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status     = status_ff;
               rsp_in.out_tag    = res_tag_ff;
               rsp_in.out_sector = res_sector_ff;
               rsp_in.going_up   = sweep_ff;
               rsp_in.pending    = ldrs_pkg::PENDING_BITS'(count_ff);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         sweep_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      scan_ff       <= scan_in;
      status_ff     <= status_in;
      res_tag_ff    <= res_tag_in;
      res_sector_ff <= res_sector_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("request count exceeds queue depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_dispatch_finds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DELETE && req_ff.op == ldrs_pkg::OP_DISPATCH) |->
      (pick.bnd_found || pick.fb_found))
      else $error("dispatch on a non-empty queue found no request");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_vec) == int'(count_ff)))
      else $error("valid cells disagree with the request count");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result raised outside the finish step");

endmodule

// ----- bench/look_scheduler_checker.sv -----
`timescale 1ns / 1ps
// Checker for the LOOK disk request scheduler: watches both item channels, keeps its own
// copy of the request queue, head position and sweep direction, and compares every result.
// Depends on ldrs_pkg for the item types and the op and status codes.
module look_scheduler_checker #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ldrs_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ldrs_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                outstanding,
   output int                checked,
   output int                rejected_adds,
   output int                empty_dispatches,
   output int                missed_removes
);

   logic [ldrs_pkg::SECTOR_BITS-1:0] slot_sector [QUEUE_DEPTH];
   logic [ldrs_pkg::TAG_BITS-1:0]    slot_tag    [QUEUE_DEPTH];
   bit                               slot_used   [QUEUE_DEPTH];
   int                               slot_rank   [QUEUE_DEPTH];
   logic [ldrs_pkg::SECTOR_BITS-1:0] head_sector;
   bit                               sweeping_up;
   int                               held_count;
   ldrs_pkg::rsp_type                scheduled_outcomes [$];

   task automatic report(input string field, input logic [63:0] got,
                         input logic [63:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      fail_count++;
   endtask

   function automatic void drop_slot(input int k);
      int age;
      age = slot_rank[k];
      slot_used[k] = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (slot_used[i] && slot_rank[i] > age) begin
            slot_rank[i]--;
         end
      end
      held_count--;
   endfunction

   function automatic int pick_slot(input bit want_low, input bit bounded);
      int                               best;
      logic [ldrs_pkg::SECTOR_BITS-1:0] s;
      logic [ldrs_pkg::SECTOR_BITS-1:0] b;
      bit                               better;
      best = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (!slot_used[i]) continue;
         s = slot_sector[i];
         if (bounded && (want_low ? (s < head_sector) : (s > head_sector))) continue;
         if (best < 0) begin
            best = i;
         end else begin
            b = slot_sector[best];
            better = want_low ? (s < b) : (s > b);
            if (better || (s == b && slot_rank[i] < slot_rank[best])) begin
               best = i;
            end
         end
      end
      return best;
   endfunction

   function automatic ldrs_pkg::rsp_type look_step(input ldrs_pkg::req_type item);
      ldrs_pkg::rsp_type r;
      int                k;
      r = '0;
      r.status = ldrs_pkg::ST_DONE;
      case (item.op)
         ldrs_pkg::OP_ADD: begin
            if (held_count >= QUEUE_DEPTH) begin
               r.status = ldrs_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (!slot_used[i]) begin
                     slot_used[i]   = 1'b1;
                     slot_sector[i] = item.sector;
                     slot_tag[i]    = item.tag;
                     slot_rank[i]   = held_count;
                     held_count++;
                     break;
                  end
               end
            end
         end
         ldrs_pkg::OP_DISPATCH: begin
            if (held_count == 0) begin
               r.status = ldrs_pkg::ST_EMPTY;
            end else begin
               k = pick_slot(sweeping_up, 1'b1);
               if (k < 0) begin
                  sweeping_up = !sweeping_up;
                  k = pick_slot(sweeping_up, 1'b0);
               end
               if (k >= 0) begin
                  r.out_tag    = slot_tag[k];
                  r.out_sector = slot_sector[k];
                  head_sector  = slot_sector[k];
                  drop_slot(k);
               end
            end
         end
         ldrs_pkg::OP_REMOVE: begin
            k = -1;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (slot_used[i] && slot_tag[i] == item.tag &&
                   (k < 0 || slot_rank[i] < slot_rank[k])) begin
                  k = i;
               end
            end
            if (k < 0) begin
               r.status = ldrs_pkg::ST_NOT_FOUND;
            end else begin
               drop_slot(k);
            end
         end
         default: begin
         end
      endcase
      r.going_up = sweeping_up;
      r.pending  = held_count[ldrs_pkg::PENDING_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      ldrs_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_used[i] = 1'b0;
            slot_rank[i] = 0;
         end
         head_sector = '0;
         sweeping_up = 1'b1;
         held_count  = 0;
         scheduled_outcomes.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (scheduled_outcomes.size() == 0) begin
               report("unexpected result, status", 64'(rsp_data.status), 64'(0));
            end else begin
               want = scheduled_outcomes.pop_front();
               checked++;
               if (want.status == ldrs_pkg::ST_FULL) rejected_adds++;
               if (want.status == ldrs_pkg::ST_EMPTY) empty_dispatches++;
               if (want.status == ldrs_pkg::ST_NOT_FOUND) missed_removes++;
               if (rsp_data.status !== want.status)
                  report("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.out_tag !== want.out_tag)
                  report("out_tag", 64'(rsp_data.out_tag), 64'(want.out_tag));
               if (rsp_data.out_sector !== want.out_sector)
                  report("out_sector", 64'(rsp_data.out_sector), 64'(want.out_sector));
               if (rsp_data.going_up !== want.going_up)
                  report("going_up", 64'(rsp_data.going_up), 64'(want.going_up));
               if (rsp_data.pending !== want.pending)
                  report("pending", 64'(rsp_data.pending), 64'(want.pending));
            end
         end
         if (req_valid && req_ready) begin
            scheduled_outcomes.push_back(look_step(req_data));
         end
         outstanding <= scheduled_outcomes.size();
      end
   end

endmodule

// ----- bench/look_disk_request_scheduler_test.sv -----
`timescale 1ns / 1ps
// Top of the LOOK disk request scheduler test: clock, reset, request and result traffic,
// a stall watchdog and the verdict. Depends on ldrs_pkg, the scheduler and the checker.
module look_disk_request_scheduler_test;

   localparam int QUEUE_DEPTH     = 32;
   localparam int ITEMS_PER_PHASE = 284;
   localparam int STALL_LIMIT     = 4000;
   localparam int HOLD_CYCLES     = 400;
   localparam int TAIL_CYCLES     = 40;
   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam logic [ldrs_pkg::SECTOR_BITS-1:0] SECTOR_MAX = '1;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ldrs_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ldrs_pkg::rsp_type rsp_data;

   int   send_idle_pct = 0;
   int   rsp_idle_pct  = 0;
   logic hold_go       = 1'b0;
   int   hold_left     = 0;
   bit   hold_done     = 1'b0;
   int   idle_cycles   = 0;
   int   sent_items    = 0;
   int   ignored_items = 0;
   int   fail_count;
   int   outstanding;
   int   checked;
   int   rejected_adds;
   int   empty_dispatches;
   int   missed_removes;

   look_disk_request_scheduler #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   look_scheduler_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .checked         (checked),
      .rejected_adds   (rejected_adds),
      .empty_dispatches(empty_dispatches),
      .missed_removes  (missed_removes)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("look_disk_request_scheduler_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input ldrs_pkg::req_type item);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      if (item.op == OP_UNDEFINED) ignored_items++;
   endtask

   task automatic send_op(input logic [1:0] op,
                          input logic [ldrs_pkg::SECTOR_BITS-1:0] sector,
                          input logic [ldrs_pkg::TAG_BITS-1:0] tag);
      ldrs_pkg::req_type item;
      item.op     = op;
      item.sector = sector;
      item.tag    = tag;
      send_item(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic roll_burst(output burst_type kind, output int length);
      int roll;
      roll = $urandom_range(99);
      kind = roll < 40 ? BURST_FILL : roll < 70 ? BURST_DRAIN : BURST_MIXED;
      length = $urandom_range(70, 30);
   endtask

   function automatic ldrs_pkg::req_type random_request(input burst_type kind);
      ldrs_pkg::req_type item;
      int                roll;
      logic [63:0]       wide;
      roll = $urandom_range(99);
      case (kind)
         BURST_FILL:
            item.op = roll < 75 ? ldrs_pkg::OP_ADD : roll < 88 ? ldrs_pkg::OP_DISPATCH :
                      roll < 98 ? ldrs_pkg::OP_REMOVE : OP_UNDEFINED;
         BURST_DRAIN:
            item.op = roll < 15 ? ldrs_pkg::OP_ADD : roll < 83 ? ldrs_pkg::OP_DISPATCH :
                      roll < 98 ? ldrs_pkg::OP_REMOVE : OP_UNDEFINED;
         default:
            item.op = roll < 40 ? ldrs_pkg::OP_ADD : roll < 75 ? ldrs_pkg::OP_DISPATCH :
                      roll < 98 ? ldrs_pkg::OP_REMOVE : OP_UNDEFINED;
      endcase
      wide = {$urandom, $urandom};
      roll = $urandom_range(99);
      if (roll < 30) begin
         item.sector = '0;
         item.sector[5:0] = wide[5:0];
      end else if (roll < 40) begin
         case (wide[1:0])
            2'd0: item.sector = '0;
            2'd1: item.sector = ldrs_pkg::SECTOR_BITS'(1);
            2'd2: item.sector = SECTOR_MAX - ldrs_pkg::SECTOR_BITS'(1);
            default: item.sector = SECTOR_MAX;
         endcase
      end else begin
         item.sector = wide[ldrs_pkg::SECTOR_BITS-1:0];
      end
      if ($urandom_range(99) < 60) begin
         item.tag = '0;
         item.tag[3:0] = wide[51:48];
      end else begin
         item.tag = wide[63:56];
      end
      return item;
   endfunction

   initial begin : stimulus
      ldrs_pkg::req_type item;
      burst_type         kind;
      int                burst_left;
      int                counted;
      send_idle_pct = 17;
      rsp_idle_pct  = 71;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_REMOVE, '0, 8'h55);
      send_op(OP_UNDEFINED, SECTOR_MAX, 8'hFF);
      send_op(ldrs_pkg::OP_ADD, 48'd100, 8'h00);
      send_op(ldrs_pkg::OP_ADD, SECTOR_MAX, 8'hFF);
      send_op(ldrs_pkg::OP_ADD, '0, 8'h01);
      send_op(ldrs_pkg::OP_ADD, 48'd100, 8'h02);
      send_op(ldrs_pkg::OP_ADD, 48'd50, 8'h03);
      send_op(ldrs_pkg::OP_ADD, 48'd100, 8'h03);
      send_op(ldrs_pkg::OP_REMOVE, '0, 8'h03);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_ADD, 48'd10, 8'hAA);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_ADD, 48'd5, 8'h55);
      send_op(ldrs_pkg::OP_ADD, 48'd20, 8'h5A);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(ldrs_pkg::OP_DISPATCH, '0, '0);
      send_op(OP_UNDEFINED, '0, '0);
      send_op(ldrs_pkg::OP_REMOVE, '0, 8'hFF);
      wait_drained();

      burst_left = 0;
      kind = BURST_MIXED;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               rsp_idle_pct  = 71;
            end
            1: begin
               send_idle_pct = 71;
               rsp_idle_pct  = 17;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
               hold_go <= 1'b1;
            end
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if (burst_left == 0) begin
               roll_burst(kind, burst_left);
            end
            item = random_request(kind);
            send_item(item);
            burst_left--;
            if (item.op != OP_UNDEFINED) counted++;
         end
         if (phase == 0) wait_drained();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d with an undefined op) across three idling mixes;",
               sent_items, ignored_items);
      $display({"checked %0d results: %0d full-queue rejects, %0d empty dispatches, ",
                "%0d unknown tags."},
               checked, rejected_adds, empty_dispatches, missed_removes);
      if (fail_count == 0) begin
         $display("look_disk_request_scheduler_test passed");
      end else begin
         $display("look_disk_request_scheduler_test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ldrs_pkg.sv
rtl/ldrs_cell.sv
rtl/ldrs_picker.sv
rtl/look_disk_request_scheduler.sv
bench/look_scheduler_checker.sv
bench/look_disk_request_scheduler_test.sv
